@@ sv/lbst_pkg.sv @@
// Package for the loopback self-test sequencer: phase codes, pattern and item types,
// stream widths and the last step index of each phase.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps

package lbst_pkg;

    localparam int SETTLE_W   = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_PAD_W  = 4;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_A_LH,
        PH_A_HL,
        PH_D_E,
        PH_E_D,
        PH_C_F,
        PH_W1_A,
        PH_W1_C,
        PH_W1_D,
        PH_W0_A,
        PH_W0_C,
        PH_W0_D
    } t_phase;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_TICK  = 1'b1
    } t_action;

    typedef struct packed {
        logic [7:0] a;
        logic       a_low;
        logic [7:0] c;
        logic [3:0] d;
        logic [3:0] e;
        logic       d_drv;
    } t_drives;

    typedef struct packed {
        t_action    action;
        logic [7:0] pins_a;
        logic [3:0] pins_d;
        logic [3:0] pins_e;
        logic [7:0] pins_f;
    } t_item;

    typedef struct packed {
        t_drives    drv;
        logic       busy;
        logic       done;
        logic [7:0] err_a;
        logic [7:0] err_d;
        logic [7:0] err_e;
        logic [7:0] err_f;
    } t_result;

    function automatic logic [7:0] last_step(input t_phase ph);
        logic [7:0] v;
        case (ph)
            PH_A_LH, PH_A_HL, PH_D_E, PH_E_D: v = 8'd15;
            PH_C_F:                           v = 8'd255;
            PH_W1_C, PH_W0_C:                 v = 8'd7;
            PH_W1_A, PH_W1_D, PH_W0_A, PH_W0_D: v = 8'd3;
            default:                          v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/lbst_pattern.sv @@
// Pattern decoder: the levels and directions driven on ports A, C, D and E for
// one phase and step of the test sequence. Depends on lbst_pkg.
`timescale 1ns / 1ps

module lbst_pattern
    import lbst_pkg::*;
(
    input  t_phase     i_phase,
    input  logic [7:0] i_index,
    output t_drives    o_drives
);

    logic [7:0] w_bit;

    assign w_bit = 8'd1 << i_index[2:0];

    always_comb begin
        o_drives       = '0;
        o_drives.a_low = 1'b1;
        o_drives.d_drv = 1'b1;
        case (i_phase)
            PH_IDLE: begin
                o_drives.a_low = 1'b0;
                o_drives.d_drv = 1'b0;
            end
            PH_A_LH: begin
                o_drives.a = {4'h0, i_index[3:0]};
            end
            PH_A_HL: begin
                o_drives.a     = {i_index[3:0], 4'h0};
                o_drives.a_low = 1'b0;
            end
            PH_D_E: begin
                o_drives.d = i_index[3:0];
            end
            PH_E_D: begin
                o_drives.e     = i_index[3:0];
                o_drives.d_drv = 1'b0;
            end
            PH_C_F: begin
                o_drives.c = i_index;
            end
            PH_W1_A: begin
                o_drives.a = {4'h0, w_bit[3:0]};
            end
            PH_W1_C: begin
                o_drives.c = w_bit;
            end
            PH_W1_D: begin
                o_drives.d = w_bit[3:0];
            end
            PH_W0_A: begin
                o_drives.a = {4'h0, ~w_bit[3:0]};
                o_drives.c = 8'hFF;
                o_drives.d = 4'hF;
                o_drives.e = 4'hF;
            end
            PH_W0_C: begin
                o_drives.a = 8'h0F;
                o_drives.c = ~w_bit;
                o_drives.d = 4'hF;
                o_drives.e = 4'hF;
            end
            PH_W0_D: begin
                o_drives.a = 8'h0F;
                o_drives.c = 8'hFF;
                o_drives.d = ~w_bit[3:0];
                o_drives.e = 4'hF;
            end
            default: begin
                o_drives.a_low = 1'b0;
                o_drives.d_drv = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/lbst_engine.sv @@
// Sequencer state and step logic: settle counter, phase and step registers,
// error accumulation and the result for each request. Depends on lbst_pkg, lbst_pattern.
`timescale 1ns / 1ps

module lbst_engine
    import lbst_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  t_item               i_item,
    input  logic [SETTLE_W-1:0] i_settle_ticks,
    output t_result             o_result
);

    t_phase              r_phase, n_phase;
    logic [7:0]          r_index, n_index;
    logic [SETTLE_W-1:0] r_count, n_count;
    logic [7:0]          r_err_a, n_err_a;
    logic [7:0]          r_err_d, n_err_d;
    logic [7:0]          r_err_e, n_err_e;
    logic [7:0]          r_err_f, n_err_f;
    logic                r_done, n_done;
    t_drives             w_cur;
    t_drives             w_nxt;

    lbst_pattern u_cur (
        .i_phase  (r_phase),
        .i_index  (r_index),
        .o_drives (w_cur)
    );

    lbst_pattern u_nxt (
        .i_phase  (n_phase),
        .i_index  (n_index),
        .o_drives (w_nxt)
    );

    always_comb begin
        n_phase = r_phase;
        n_index = r_index;
        n_count = r_count;
        n_err_a = r_err_a;
        n_err_d = r_err_d;
        n_err_e = r_err_e;
        n_err_f = r_err_f;
        n_done  = r_done;
        if (i_item.action == ACT_START) begin
            n_phase = PH_A_LH;
            n_index = '0;
            n_count = '0;
            n_err_a = '0;
            n_err_d = '0;
            n_err_e = '0;
            n_err_f = '0;
            n_done  = 1'b0;
        end else if (r_phase != PH_IDLE) begin
            if (r_count < i_settle_ticks) begin
                n_count = r_count + 1'b1;
            end else begin
                n_count = '0;
                case (r_phase)
                    PH_A_LH: begin
                        n_err_a = r_err_a | ((i_item.pins_a ^ {w_cur.a[3:0], 4'h0}) & 8'hF0);
                    end
                    PH_A_HL: begin
                        n_err_a = r_err_a | ((i_item.pins_a ^ {4'h0, w_cur.a[7:4]}) & 8'h0F);
                    end
                    PH_D_E: begin
                        n_err_e = r_err_e | {i_item.pins_e ^ w_cur.d, 4'h0};
                    end
                    PH_E_D: begin
                        n_err_d = r_err_d | {i_item.pins_d ^ w_cur.e, 4'h0};
                    end
                    PH_C_F: begin
                        n_err_f = r_err_f | (i_item.pins_f ^ w_cur.c);
                    end
                    default: begin
                        n_err_a = r_err_a | ((i_item.pins_a ^ {w_cur.a[3:0], 4'h0}) & 8'hF0);
                        n_err_f = r_err_f | (i_item.pins_f ^ w_cur.c);
                        n_err_e = r_err_e | {i_item.pins_e ^ w_cur.d, 4'h0};
                    end
                endcase
                if (r_index == last_step(r_phase)) begin
                    n_index = '0;
                    if (r_phase == PH_W0_D) begin
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_phase = t_phase'(r_phase + 4'd1);
                    end
                end else begin
                    n_index = r_index + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_index <= '0;
            r_count <= '0;
            r_err_a <= '0;
            r_err_d <= '0;
            r_err_e <= '0;
            r_err_f <= '0;
            r_done  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_index <= n_index;
            r_count <= n_count;
            r_err_a <= n_err_a;
            r_err_d <= n_err_d;
            r_err_e <= n_err_e;
            r_err_f <= n_err_f;
            r_done  <= n_done;
        end
    end

    always_comb begin
        o_result.drv   = w_nxt;
        o_result.busy  = (n_phase != PH_IDLE);
        o_result.done  = n_done;
        o_result.err_a = n_err_a;
        o_result.err_d = n_err_d;
        o_result.err_e = n_err_e;
        o_result.err_f = n_err_f;
    end

endmodule

@@ sv/io_loopback_selftest_sequencer.sv @@
// Each request is registered in the input stage and its result in the output stage.
// Throughput: one request per cycle unless the output stalls; state steps per request.
// Settle time and sampling are counted in requests (ticks), not in clock cycles.
// Reset: synchronous, active low; clears both stream stages and the sequencer state,
// and sets the settle time to one tick.
`timescale 1ns / 1ps

module io_loopback_selftest_sequencer
    import lbst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // pins_a [7:0], pins_d_high [11:8], pins_e_high [15:12], pins_f [23:16]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // action [0]
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // drive_a [7:0], a_low_drives [8], drive_c [16:9], drive_d_high [20:17],
    // drive_e_high [24:21], d_drives [25], busy_res [26], done_res [27],
    // err_a [35:28], err_d [43:36], err_e [51:44], err_f [59:52], zero [63:60]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [SETTLE_W-1:0]   i_cfg_data
);

    logic                  r_in_valid;
    t_item                 r_in_item;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [SETTLE_W-1:0]   r_settle_ticks;
    logic                  w_fire;
    t_result               w_result;

    assign w_fire          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_fire;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ticks <= SETTLE_W'(1);
        end else if (i_cfg_valid) begin
            r_settle_ticks <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_item.action <= t_action'(i_s_axis_tuser);
            r_in_item.pins_a <= i_s_axis_tdata[7:0];
            r_in_item.pins_d <= i_s_axis_tdata[11:8];
            r_in_item.pins_e <= i_s_axis_tdata[15:12];
            r_in_item.pins_f <= i_s_axis_tdata[23:16];
        end
    end

    lbst_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_fire),
        .i_item         (r_in_item),
        .i_settle_ticks (r_settle_ticks),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= {{OUT_PAD_W{1'b0}},
                           w_result.err_f, w_result.err_e, w_result.err_d, w_result.err_a,
                           w_result.done, w_result.busy,
                           w_result.drv.d_drv, w_result.drv.e, w_result.drv.d,
                           w_result.drv.c, w_result.drv.a_low, w_result.drv.a};
        end
    end

endmodule

@@ sv/lbst_checker.sv @@
// Port-level checks for the loopback self-test sequencer, with the bind that
// attaches them to the top level. Depends on lbst_pkg and io_loopback_selftest_sequencer.
`timescale 1ns / 1ps

module lbst_port_checks
    import lbst_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    // A result never claims to be running and finished at once.
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[26] && o_m_axis_tdata[27]))
        else $error("busy and done both set");

    // With no test running, nothing is driven and both directions are released.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[26]) |-> (o_m_axis_tdata[25:0] == 26'd0))
        else $error("drive fields nonzero while idle");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("result changed while stalled");

    // Reset leaves no result valid on the output straight after it.
    a_no_spurious: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind io_loopback_selftest_sequencer lbst_port_checks u_lbst_port_checks (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
